### design/tpq_pkg.sv
// shared types, constants and codes of the timer priority queue
// no dependencies; every other file of the block imports this package
package tpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 32;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);
    localparam int FIELD_W   = 32;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CANCEL   = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    localparam logic [1:0] KIND_SCHED      = 2'd0;
    localparam logic [1:0] KIND_CANCEL     = 2'd1;
    localparam logic [1:0] KIND_FIRED      = 2'd2;
    localparam logic [1:0] KIND_EMPTY_TICK = 2'd3;

    localparam logic [FIELD_W-1:0] EXPIRY_EMPTY = '1;
    localparam logic [FIELD_W-1:0] EXPIRY_SAT   = {1'b0, {(FIELD_W-1){1'b1}}};

    typedef struct packed {
        logic [TIME_BITS-1:0] expiry;
        logic [ID_BITS-1:0]   id;
        logic                 live;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_LOAD
    } cell_op_t;

    typedef enum logic [1:0] {
        MODE_SCHED,
        MODE_CANCEL,
        MODE_TICK
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_PASS,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

### design/tpq_cell.sv
// one storage cell of the timer store: holds one entry and takes its neighbor's
// entry or a loaded entry on command; depends on tpq_pkg
module tpq_cell
    import tpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  entry_t   shift_in,
    input  entry_t   load_in,
    output entry_t   q
);

    entry_t               q_next;
    logic                 live_reg;
    logic [TIME_BITS-1:0] expiry_reg;
    logic [ID_BITS-1:0]   id_reg;

    assign q = {expiry_reg, id_reg, live_reg};

    always_comb
    begin
        case (op)
            CELL_SHIFT: q_next = shift_in;
            CELL_LOAD:  q_next = load_in;
            default:    q_next = q;
        endcase
    end

    // only the live mark is control state, the rest is payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else
        begin
            live_reg <= q_next.live;
        end
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= q_next.expiry;
        id_reg     <= q_next.id;
    end

endmodule

### design/tpq_fire_fifo.sv
// shift-line queue of fired timer ids, held until the tick's results go out
// depends on tpq_pkg
module tpq_fire_fifo
    import tpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [ID_BITS-1:0]  push_id,
    input  logic                pop,
    output logic [ID_BITS-1:0]  head,
    output logic [CNT_BITS-1:0] count
);

    logic [ID_BITS-1:0]  q_reg [CAPACITY];
    logic [ID_BITS-1:0]  q_next [CAPACITY];
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (pop)
            begin
                if (push && (CNT_BITS'(i) + CNT_BITS'(1)) == count_reg)
                    q_next[i] = push_id;
                else if (i < CAPACITY - 1)
                    q_next[i] = q_reg[i + 1];
                else
                    q_next[i] = q_reg[i];
            end
            else if (push && CNT_BITS'(i) == count_reg)
            begin
                q_next[i] = push_id;
            end
            else
            begin
                q_next[i] = q_reg[i];
            end
        end
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            q_reg[i] <= q_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head  = q_reg[0];
    assign count = count_reg;

endmodule

### design/timer_priority_queue_core.sv
// timer priority queue: a ring of entry cells scanned by rotation, a sequencer,
// and a queue of fired ids; depends on tpq_pkg, tpq_cell and tpq_fire_fifo
// sequence: a schedule first reclaims cancelled entries if the store is full, then loads;
//   a schedule or cancel then rotates the ring once before its result; a tick rotates once
//   more than it pops before its first result, then gives one result per cycle while
//   m_axis_tready is high; an empty store skips the rotation; one item at a time
// reset: store empty, time and id counter zero; stored entries need no clearing
module timer_priority_queue_core
    import tpq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd [1:0], delay_ms [33:2], cancel_id [65:34], zero fill [71:66]
    input  logic [71:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_id [31:0], accepted [32], cancel_found [33], fired_id [65:34],
    // next_expiry_ms [97:66], zero fill [103:98]
    output logic [103:0] m_axis_tdata,
    // kind [1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic [IDX_BITS-1:0]  step_reg, step_next;
    logic [TIME_BITS-1:0] new_exp_reg, new_exp_next;
    logic [FIELD_W-1:0]   cid_reg, cid_next;
    logic                 found_reg, found_next;
    logic                 acc_reg, acc_next;
    logic [ID_BITS-1:0]   new_id_reg, new_id_next;
    entry_t               best_reg, best_next;
    logic [IDX_BITS-1:0]  best_slot_reg, best_slot_next;
    entry_t               top_reg, top_next;
    logic [FIELD_W-1:0]   nx_reg, nx_next;
    logic                 rec_reg, rec_next;

    cell_op_t             cell_op [CAPACITY];
    entry_t               cell_q [CAPACITY];
    entry_t               shift_in [CAPACITY];
    entry_t               load_in;
    entry_t               head_mod;
    logic [CAPACITY-1:0]  dead_vec;
    logic                 in_range;
    logic                 better;
    logic                 cancel_hit;
    logic [TIME_BITS:0]   sum_w;
    logic [TIME_BITS-1:0] diff_w;

    logic                 fifo_push;
    logic                 fifo_pop;
    logic [ID_BITS-1:0]   fifo_head;
    logic [CNT_BITS-1:0]  fifo_count;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            if (g < CAPACITY - 1)
            begin : g_mid
                assign shift_in[g] = cell_q[g + 1];
            end
            else
            begin : g_end
                assign shift_in[g] = head_mod;
            end
            tpq_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .op       (cell_op[g]),
                .shift_in (shift_in[g]),
                .load_in  (load_in),
                .q        (cell_q[g])
            );
        end
    endgenerate

    tpq_fire_fifo u_fire (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fifo_push),
        .push_id (best_reg.id),
        .pop     (fifo_pop),
        .head    (fifo_head),
        .count   (fifo_count)
    );

    // head of the ring holds slot step_reg during a pass
    always_comb
    begin
        in_range   = {1'b0, step_reg} < cnt_reg;
        cancel_hit = (mode_reg == MODE_CANCEL) && in_range && cell_q[0].live
                     && (64'(cell_q[0].id) == 64'(cid_reg));
        head_mod   = cell_q[0];
        if (cancel_hit)
            head_mod.live = 1'b0;
        better = (step_reg == '0) || (cell_q[0].expiry < best_reg.expiry)
                 || ((cell_q[0].expiry == best_reg.expiry) && (cell_q[0].id < best_reg.id));
        for (int i = 0; i < CAPACITY; i++)
            dead_vec[i] = (CNT_BITS'(i) < cnt_reg) && !cell_q[i].live;
        sum_w  = {1'b0, now_reg} + (TIME_BITS + 1)'(s_axis_tdata[33:2]);
        diff_w = best_reg.expiry - now_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        next_id_next   = next_id_reg;
        step_next      = step_reg;
        new_exp_next   = new_exp_reg;
        cid_next       = cid_reg;
        found_next     = found_reg;
        acc_next       = acc_reg;
        new_id_next    = new_id_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        top_next       = top_reg;
        nx_next        = nx_reg;
        rec_next       = rec_reg;
        load_in        = top_reg;
        fifo_push      = 1'b0;
        fifo_pop       = 1'b0;
        s_axis_tready  = 1'b0;
        m_axis_tvalid  = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            cell_op[i] = CELL_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                step_next     = '0;
                rec_next      = 1'b0;
                if (s_axis_tvalid)
                begin
                    unique case (s_axis_tdata[1:0])
                        CMD_SCHEDULE:
                        begin
                            new_exp_next = sum_w[TIME_BITS] ? '1 : sum_w[TIME_BITS-1:0];
                            mode_next    = MODE_SCHED;
                            state_next   = ST_SCHED;
                        end
                        CMD_CANCEL:
                        begin
                            cid_next   = s_axis_tdata[65:34];
                            found_next = 1'b0;
                            mode_next  = MODE_CANCEL;
                            state_next = ST_PASS;
                        end
                        CMD_TICK:
                        begin
                            now_next   = now_reg + TIME_BITS'(1);
                            mode_next  = MODE_TICK;
                            state_next = ST_PASS;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCHED:
            begin
                if ((cnt_reg == CNT_BITS'(CAPACITY) || rec_reg) && (|dead_vec))
                begin
                    // drop the lowest cancelled entry, the cells above it move down;
                    // once started, this repeats until no cancelled entry is left
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (|(dead_vec & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i))))
                            cell_op[i] = CELL_SHIFT;
                    end
                    cnt_next = cnt_reg - CNT_BITS'(1);
                    rec_next = 1'b1;
                end
                else if (cnt_reg < CNT_BITS'(CAPACITY))
                begin
                    load_in.expiry = new_exp_reg;
                    load_in.id     = next_id_reg;
                    load_in.live   = 1'b1;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (CNT_BITS'(i) == cnt_reg)
                            cell_op[i] = CELL_LOAD;
                    end
                    cnt_next     = cnt_reg + CNT_BITS'(1);
                    next_id_next = next_id_reg + ID_BITS'(1);
                    acc_next     = 1'b1;
                    new_id_next  = next_id_reg;
                    state_next   = ST_PASS;
                end
                else
                begin
                    acc_next    = 1'b0;
                    new_id_next = '0;
                    state_next  = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        cell_op[i] = CELL_SHIFT;
                    if (in_range && better)
                    begin
                        best_next      = cell_q[0];
                        best_slot_next = step_reg;
                    end
                    if (({1'b0, step_reg} + CNT_BITS'(1)) == cnt_reg)
                        top_next = head_mod;
                    if (cancel_hit)
                        found_next = 1'b1;
                    step_next = step_reg + IDX_BITS'(1);
                    if (step_reg == IDX_BITS'(CAPACITY - 1))
                        state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                step_next = '0;
                if (mode_reg == MODE_TICK && cnt_reg != '0 && best_reg.expiry <= now_reg)
                begin
                    // the top entry fills the popped slot
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (IDX_BITS'(i) == best_slot_reg)
                            cell_op[i] = CELL_LOAD;
                    end
                    cnt_next   = cnt_reg - CNT_BITS'(1);
                    fifo_push  = best_reg.live;
                    state_next = ST_PASS;
                end
                else
                begin
                    if (cnt_reg == '0)
                        nx_next = EXPIRY_EMPTY;
                    else if (best_reg.expiry <= now_reg)
                        nx_next = '0;
                    else if (|diff_w[TIME_BITS-1:FIELD_W-1])
                        nx_next = EXPIRY_SAT;
                    else
                        nx_next = FIELD_W'(diff_w);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    fifo_pop = (fifo_count != '0);
                    if (!(mode_reg == MODE_TICK && fifo_count > CNT_BITS'(1)))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_SCHED;
            cnt_reg     <= '0;
            now_reg     <= '0;
            next_id_reg <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            cnt_reg     <= cnt_next;
            now_reg     <= now_next;
            next_id_reg <= next_id_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_exp_reg   <= new_exp_next;
        cid_reg       <= cid_next;
        found_reg     <= found_next;
        acc_reg       <= acc_next;
        new_id_reg    <= new_id_next;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        top_reg       <= top_next;
        nx_reg        <= nx_next;
        rec_reg       <= rec_next;
    end

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tuser = KIND_SCHED;
        m_axis_tlast = 1'b1;
        unique case (mode_reg)
            MODE_SCHED:
            begin
                m_axis_tuser       = KIND_SCHED;
                m_axis_tdata[31:0] = FIELD_W'(new_id_reg);
                m_axis_tdata[32]   = acc_reg;
            end
            MODE_CANCEL:
            begin
                m_axis_tuser     = KIND_CANCEL;
                m_axis_tdata[33] = found_reg;
            end
            default:
            begin
                if (fifo_count == '0)
                begin
                    m_axis_tuser = KIND_EMPTY_TICK;
                end
                else
                begin
                    m_axis_tuser        = KIND_FIRED;
                    m_axis_tdata[65:34] = FIELD_W'(fifo_head);
                    m_axis_tlast        = (fifo_count == CNT_BITS'(1));
                end
            end
        endcase
        m_axis_tdata[97:66] = nx_reg;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_BITS'(CAPACITY))
        else $error("stored count beyond capacity");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && state_next == ST_PASS)
        |=> (cnt_reg == $past(cnt_reg) - CNT_BITS'(1)))
        else $error("pop did not shrink the store");

    a_fired_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_push) |-> (fifo_count < CNT_BITS'(CAPACITY)))
        else $error("fired queue overflow");

endmodule
